// File: rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

   // result channels
   localparam logic [2:0] CH_TEXT   = 3'd0;
   localparam logic [2:0] CH_BINARY = 3'd1;
   localparam logic [2:0] CH_CLOSE  = 3'd2;
   localparam logic [2:0] CH_PING   = 3'd3;
   localparam logic [2:0] CH_PONG   = 3'd4;
   localparam logic [2:0] CH_ERROR  = 3'd5;

   // error codes
   localparam logic [1:0] ERR_BAD_OPCODE   = 2'd0;
   localparam logic [1:0] ERR_SHORT_CLOSE  = 2'd1;
   localparam logic [1:0] ERR_OVER_LENGTH  = 2'd2;

   // opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'ha;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [7:0] PONG_HDR0  = 8'h8a;
   localparam logic [63:0] PING_MAX_LEN = 64'd125;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   // register indexes
   localparam logic CSR_DEMASK_ENABLE    = 1'b0;
   localparam logic CSR_MAX_FRAME_LENGTH = 1'b1;

   localparam logic        DEMASK_ENABLE_RESET    = 1'b1;
   localparam logic [31:0] MAX_FRAME_LENGTH_RESET = 32'd67108864;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [2:0]  channel;
      logic [7:0]  data_byte;
      logic [15:0] close_code;
      logic [1:0]  error_code;
      logic        empty_res;
      logic        last;
   } rsp_type;

   // results caused by one accepted byte, item[0] goes out first
   typedef struct packed {
      logic [1:0]    count;
      rsp_type [2:0] item;
   } batch_type;

   function automatic rsp_type mk_rsp(logic [2:0] channel, logic [7:0] data_byte,
                                      logic [15:0] close_code, logic [1:0] error_code,
                                      logic empty_res, logic last);
      rsp_type r;
      r.channel    = channel;
      r.data_byte  = data_byte;
      r.close_code = close_code;
      r.error_code = error_code;
      r.empty_res  = empty_res;
      r.last       = last;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/wsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         rx_byte,
   input  wire logic               demask_enable,
   input  wire logic [31:0]        max_frame_length,
   output wsd_pkg::batch_type      batch
);

   typedef enum logic [6:0] {
      PH_HDR0    = 7'b0000001,
      PH_HDR1    = 7'b0000010,
      PH_EXT16   = 7'b0000100,
      PH_EXT64   = 7'b0001000,
      PH_MASK    = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_SINK    = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  op_ff, op_in;
   logic        text_ff, text_in;
   logic        mask_ff, mask_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] left_ff, left_in;
   logic [3:0]  hcnt_ff, hcnt_in;
   logic [1:0]  midx_ff, midx_in;
   logic [15:0] cstat_ff, cstat_in;

   logic        hdr_done;
   logic        text_sel;
   logic [2:0]  data_ch;
   logic [3:0]  cnt_next;
   logic [7:0]  key_byte;
   logic [7:0]  d;
   logic        fin;

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      text_in  = text_ff;
      mask_in  = mask_ff;
      key_in   = key_ff;
      left_in  = left_ff;
      hcnt_in  = hcnt_ff;
      midx_in  = midx_ff;
      cstat_in = cstat_ff;
      batch    = '0;
      hdr_done = 1'b0;
      text_sel = text_ff;
      data_ch  = text_ff ? wsd_pkg::CH_TEXT : wsd_pkg::CH_BINARY;
      cnt_next = hcnt_ff + 4'd1;
      key_byte = key_ff[(5'd24 - {midx_ff, 3'b000}) +: 8];
      d        = (mask_ff && demask_enable) ? (rx_byte ^ key_byte) : rx_byte;
      fin      = (left_ff == 64'd1);

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               op_in = rx_byte[3:0];
               if (rx_byte[3:0] > wsd_pkg::OP_BINARY &&
                   (rx_byte[3:0] < wsd_pkg::OP_CLOSE || rx_byte[3:0] > wsd_pkg::OP_PONG)) begin
                  batch.count   = 2'd1;
                  batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_ERROR, 8'd0, 16'd0,
                                                  wsd_pkg::ERR_BAD_OPCODE, 1'b1, 1'b1);
                  phase_in = PH_SINK;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               mask_in = rx_byte[7];
               key_in  = '0;
               hcnt_in = '0;
               left_in = '0;
               if (rx_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (rx_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  left_in = {57'd0, rx_byte[6:0]};
                  if (rx_byte[7]) begin
                     phase_in = PH_MASK;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               left_in = {left_ff[55:0], rx_byte};
               hcnt_in = cnt_next;
               if (cnt_next >= ((phase_ff == PH_EXT16) ? wsd_pkg::EXT16_BYTES
                                                       : wsd_pkg::EXT64_BYTES)) begin
                  if (mask_ff) begin
                     hcnt_in  = '0;
                     phase_in = PH_MASK;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_MASK: begin
               key_in  = {key_ff[23:0], rx_byte};
               hcnt_in = cnt_next;
               if (cnt_next >= wsd_pkg::KEY_BYTES) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               midx_in = midx_ff + 2'd1;
               left_in = left_ff - 64'd1;
               priority if (op_ff <= wsd_pkg::OP_BINARY) begin
                  batch.count   = 2'd1;
                  batch.item[0] = wsd_pkg::mk_rsp(data_ch, d, 16'd0, 2'd0, 1'b0, fin);
               end else if (op_ff == wsd_pkg::OP_CLOSE) begin
                  // first two body bytes hold the status code
                  if (hcnt_ff == 4'd0) begin
                     cstat_in = {d, 8'd0};
                     hcnt_in  = 4'd1;
                  end else if (hcnt_ff == 4'd1) begin
                     cstat_in = {cstat_ff[15:8], d};
                     hcnt_in  = 4'd2;
                     if (fin) begin
                        batch.count   = 2'd1;
                        batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_CLOSE, 8'd0,
                                                        {cstat_ff[15:8], d}, 2'd0,
                                                        1'b1, 1'b1);
                     end
                  end else begin
                     batch.count   = 2'd1;
                     batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_CLOSE, d, cstat_ff, 2'd0,
                                                     1'b0, fin);
                  end
               end else if (op_ff == wsd_pkg::OP_PING) begin
                  batch.count   = 2'd2;
                  batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_PING, d, 16'd0, 2'd0, 1'b0, fin);
                  batch.item[1] = wsd_pkg::mk_rsp(wsd_pkg::CH_PONG, d, 16'd0, 2'd0, 1'b0, fin);
               end else begin
                  // pong payload is dropped
               end
               if (fin) begin
                  phase_in = (op_ff == wsd_pkg::OP_CLOSE) ? PH_SINK : PH_HDR0;
               end
            end
            PH_SINK: begin
            end
            default: begin
               phase_in = PH_SINK;
            end
         endcase
      end

      if (hdr_done) begin
         hcnt_in  = '0;
         midx_in  = '0;
         cstat_in = '0;
         priority if (left_in > {32'd0, max_frame_length}) begin
            batch.count   = 2'd1;
            batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_ERROR, 8'd0, 16'd0,
                                            wsd_pkg::ERR_OVER_LENGTH, 1'b1, 1'b1);
            phase_in = PH_SINK;
         end else if (op_ff == wsd_pkg::OP_CLOSE && left_in == 64'd1) begin
            batch.count   = 2'd1;
            batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_ERROR, 8'd0, 16'd0,
                                            wsd_pkg::ERR_SHORT_CLOSE, 1'b1, 1'b1);
            phase_in = PH_SINK;
         end else if (op_ff == wsd_pkg::OP_PING && left_in > wsd_pkg::PING_MAX_LEN) begin
            batch.count   = 2'd1;
            batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_ERROR, 8'd0, 16'd0,
                                            wsd_pkg::ERR_OVER_LENGTH, 1'b1, 1'b1);
            phase_in = PH_SINK;
         end else begin
            // continuation keeps the last data type
            if (op_ff == wsd_pkg::OP_TEXT) begin
               text_sel = 1'b1;
            end else if (op_ff == wsd_pkg::OP_BINARY) begin
               text_sel = 1'b0;
            end
            text_in = text_sel;
            if (left_in == 64'd0) begin
               phase_in = PH_HDR0;
               priority if (op_ff <= wsd_pkg::OP_BINARY) begin
                  batch.count   = 2'd1;
                  batch.item[0] = wsd_pkg::mk_rsp(text_sel ? wsd_pkg::CH_TEXT
                                                           : wsd_pkg::CH_BINARY,
                                                  8'd0, 16'd0, 2'd0, 1'b1, 1'b1);
               end else if (op_ff == wsd_pkg::OP_CLOSE) begin
                  batch.count   = 2'd1;
                  batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_CLOSE, 8'd0, 16'd0, 2'd0,
                                                  1'b1, 1'b1);
                  phase_in = PH_SINK;
               end else if (op_ff == wsd_pkg::OP_PING) begin
                  batch.count   = 2'd3;
                  batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_PING, 8'd0, 16'd0, 2'd0,
                                                  1'b1, 1'b1);
                  batch.item[1] = wsd_pkg::mk_rsp(wsd_pkg::CH_PONG, wsd_pkg::PONG_HDR0,
                                                  16'd0, 2'd0, 1'b0, 1'b0);
                  batch.item[2] = wsd_pkg::mk_rsp(wsd_pkg::CH_PONG, 8'd0, 16'd0, 2'd0,
                                                  1'b0, 1'b1);
               end else begin
               end
            end else begin
               phase_in = PH_PAYLOAD;
               if (op_ff == wsd_pkg::OP_PING) begin
                  // pong header: opcode byte then the short length
                  batch.count   = 2'd2;
                  batch.item[0] = wsd_pkg::mk_rsp(wsd_pkg::CH_PONG, wsd_pkg::PONG_HDR0,
                                                  16'd0, 2'd0, 1'b0, 1'b0);
                  batch.item[1] = wsd_pkg::mk_rsp(wsd_pkg::CH_PONG, left_in[7:0], 16'd0,
                                                  2'd0, 1'b0, 1'b0);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         op_ff    <= '0;
         text_ff  <= 1'b0;
         mask_ff  <= 1'b0;
         key_ff   <= '0;
         left_ff  <= '0;
         hcnt_ff  <= '0;
         midx_ff  <= '0;
         cstat_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         text_ff  <= text_in;
         mask_ff  <= mask_in;
         key_ff   <= key_in;
         left_ff  <= left_in;
         hcnt_ff  <= hcnt_in;
         midx_ff  <= midx_in;
         cstat_ff <= cstat_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/wsd_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_rsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire wsd_pkg::batch_type batch,
   output logic                    room,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output wsd_pkg::rsp_type        out_item
);

   localparam int PtrW = $clog2(wsd_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(wsd_pkg::QUEUE_DEPTH + 1);

   wsd_pkg::rsp_type mem_ff [wsd_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [CntW-1:0]  add;
   logic             pop;

   // accept a byte only when a full batch still fits
   assign room      = (cnt_ff <= CntW'(wsd_pkg::QUEUE_DEPTH - wsd_pkg::MAX_RESULTS));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign add       = push ? CntW'(batch.count) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(add);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      cnt_in    = cnt_ff + add - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < wsd_pkg::MAX_RESULTS; k++) begin
         if (push && (k < int'(batch.count))) begin
            mem_ff[wr_ptr_ff + PtrW'(k)] <= batch.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Receive-side WebSocket deframer. One stream byte is taken per transfer on req_ and parsed
// in the cycle it is accepted; its results (0 to 3) go into a 4-entry result queue that
// drives rsp_ one result per cycle while rsp_ready is high. A byte can be accepted every
// cycle while the queue holds at most one result, so plain text, binary and close
// traffic runs at one byte per cycle while rsp_ready stays high; ping payload bytes give
// two results each, and so does the byte that ends a ping header (three for an empty
// ping), so the queue holds back the byte after each. A header byte gives a result only
// when it raises an error or ends the header of a ping or of an empty frame other than
// a pong. After an error or a completed close frame all further bytes are taken and
// dropped until reset. csr_ writes take effect at once and belong between frames.

module websocket_frame_deframer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_channel,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_close_code,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_empty_res,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic               demask_ff;
   logic [31:0]        max_len_ff;
   logic               accept;
   wsd_pkg::batch_type batch;
   wsd_pkg::rsp_type   head;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         demask_ff  <= wsd_pkg::DEMASK_ENABLE_RESET;
         max_len_ff <= wsd_pkg::MAX_FRAME_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wsd_pkg::CSR_DEMASK_ENABLE:    demask_ff  <= csr_wdata[0];
            wsd_pkg::CSR_MAX_FRAME_LENGTH: max_len_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   wsd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .rx_byte          (req_rx_byte),
      .demask_enable    (demask_ff),
      .max_frame_length (max_len_ff),
      .batch            (batch)
   );

   wsd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .batch     (batch),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head)
   );

   assign rsp_channel    = head.channel;
   assign rsp_data_byte  = head.data_byte;
   assign rsp_close_code = head.close_code;
   assign rsp_error_code = head.error_code;
   assign rsp_empty_res  = head.empty_res;
   assign rsp_last       = head.last;

endmodule

`default_nettype wire

// File: tb/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 1ps

import wsd_pkg::*;

typedef enum logic [2:0] {
   ST_OPCODE,
   ST_LENGTH,
   ST_EXT16,
   ST_EXT64,
   ST_KEY,
   ST_PAYLOAD,
   ST_SINK
} parse_state_e;

class deframe_scoreboard;
   rsp_type      expected_rsp[$];
   int unsigned  failures;

   logic         demask_on;
   logic [31:0]  length_limit;

   parse_state_e state;
   logic [3:0]   opcode;
   logic         is_text;
   logic         is_masked;
   logic [31:0]  key;
   logic [63:0]  remaining;
   logic [3:0]   hdr_bytes;
   logic [1:0]   key_pos;
   logic [15:0]  status_code;

   function new();
      failures     = 0;
      demask_on    = DEMASK_ENABLE_RESET;
      length_limit = MAX_FRAME_LENGTH_RESET;
      state        = ST_OPCODE;
      opcode       = 4'h0;
      is_text      = 1'b0;
      is_masked    = 1'b0;
      key          = '0;
      remaining    = '0;
      hdr_bytes    = '0;
      key_pos      = '0;
      status_code  = '0;
   endfunction

   function void write_reg(logic idx, logic [31:0] value);
      if (idx == CSR_DEMASK_ENABLE) begin
         demask_on = value[0];
      end else begin
         length_limit = value;
      end
   endfunction

   function void push(logic [2:0] ch, logic [7:0] data, logic [15:0] code,
                      logic [1:0] err, logic empty, logic last);
      rsp_type r;
      r.channel    = ch;
      r.data_byte  = data;
      r.close_code = code;
      r.error_code = err;
      r.empty_res  = empty;
      r.last       = last;
      expected_rsp.push_back(r);
   endfunction

   function void flag_error(logic [1:0] err);
      push(CH_ERROR, 8'h00, 16'h0000, err, 1'b1, 1'b1);
      state = ST_SINK;
   endfunction

   function logic [2:0] data_channel();
      return is_text ? CH_TEXT : CH_BINARY;
   endfunction

   function void end_header();
      hdr_bytes   = '0;
      key_pos     = '0;
      status_code = '0;
      if (remaining > {32'd0, length_limit}) begin
         flag_error(ERR_OVER_LENGTH);
      end else if (opcode == OP_CLOSE && remaining == 64'd1) begin
         flag_error(ERR_SHORT_CLOSE);
      end else if (opcode == OP_PING && remaining > PING_MAX_LEN) begin
         flag_error(ERR_OVER_LENGTH);
      end else begin
         if (opcode == OP_TEXT) begin
            is_text = 1'b1;
         end else if (opcode == OP_BINARY) begin
            is_text = 1'b0;
         end
         if (remaining == 64'd0) begin
            state = ST_OPCODE;
            if (opcode <= OP_BINARY) begin
               push(data_channel(), 8'h00, 16'h0000, 2'd0, 1'b1, 1'b1);
            end else if (opcode == OP_CLOSE) begin
               push(CH_CLOSE, 8'h00, 16'h0000, 2'd0, 1'b1, 1'b1);
               state = ST_SINK;
            end else if (opcode == OP_PING) begin
               push(CH_PING, 8'h00, 16'h0000, 2'd0, 1'b1, 1'b1);
               push(CH_PONG, PONG_HDR0, 16'h0000, 2'd0, 1'b0, 1'b0);
               push(CH_PONG, 8'h00, 16'h0000, 2'd0, 1'b0, 1'b1);
            end
         end else begin
            state = ST_PAYLOAD;
            // pong reply header goes out before any ping payload
            if (opcode == OP_PING) begin
               push(CH_PONG, PONG_HDR0, 16'h0000, 2'd0, 1'b0, 1'b0);
               push(CH_PONG, remaining[7:0], 16'h0000, 2'd0, 1'b0, 1'b0);
            end
         end
      end
   endfunction

   function void end_length();
      if (is_masked) begin
         hdr_bytes = '0;
         state     = ST_KEY;
      end else begin
         end_header();
      end
   endfunction

   function void payload_byte(logic [7:0] b);
      logic [7:0] d;
      logic       fin;
      d = b;
      if (is_masked && demask_on) begin
         d = d ^ key[31 - 8 * key_pos -: 8];
      end
      key_pos   = key_pos + 2'd1;
      remaining = remaining - 64'd1;
      fin       = (remaining == 64'd0);
      if (opcode <= OP_BINARY) begin
         push(data_channel(), d, 16'h0000, 2'd0, 1'b0, fin);
      end else if (opcode == OP_CLOSE) begin
         // first two body bytes form the status code
         if (hdr_bytes == 4'd0) begin
            status_code = {d, 8'h00};
            hdr_bytes   = 4'd1;
         end else if (hdr_bytes == 4'd1) begin
            status_code[7:0] = d;
            hdr_bytes        = 4'd2;
            if (fin) begin
               push(CH_CLOSE, 8'h00, status_code, 2'd0, 1'b1, 1'b1);
            end
         end else begin
            push(CH_CLOSE, d, status_code, 2'd0, 1'b0, fin);
         end
      end else if (opcode == OP_PING) begin
         push(CH_PING, d, 16'h0000, 2'd0, 1'b0, fin);
         push(CH_PONG, d, 16'h0000, 2'd0, 1'b0, fin);
      end
      if (fin) begin
         state = (opcode == OP_CLOSE) ? ST_SINK : ST_OPCODE;
      end
   endfunction

   function void take_byte(logic [7:0] b);
      case (state)
         ST_OPCODE: begin
            opcode = b[3:0];
            if (opcode inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}) begin
               state = ST_LENGTH;
            end else begin
               flag_error(ERR_BAD_OPCODE);
            end
         end
         ST_LENGTH: begin
            is_masked = b[7];
            key       = '0;
            hdr_bytes = '0;
            remaining = '0;
            if (b[6:0] == LEN7_EXT16) begin
               state = ST_EXT16;
            end else if (b[6:0] == LEN7_EXT64) begin
               state = ST_EXT64;
            end else begin
               remaining = {57'd0, b[6:0]};
               end_length();
            end
         end
         ST_EXT16, ST_EXT64: begin
            remaining = {remaining[55:0], b};
            hdr_bytes = hdr_bytes + 4'd1;
            if (hdr_bytes >= ((state == ST_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
               end_length();
            end
         end
         ST_KEY: begin
            key       = {key[23:0], b};
            hdr_bytes = hdr_bytes + 4'd1;
            if (hdr_bytes >= KEY_BYTES) begin
               end_header();
            end
         end
         ST_PAYLOAD: begin
            payload_byte(b);
         end
         default: begin
            state = ST_SINK;
         end
      endcase
   endfunction

   function void check_rsp(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         $error("result with nothing expected: channel %0d data %0h", got.channel,
                got.data_byte);
         failures++;
         return;
      end
      want = expected_rsp.pop_front();
      if (got.channel !== want.channel) begin
         $error("channel: expected %0d, got %0d", want.channel, got.channel);
         failures++;
      end
      if (got.data_byte !== want.data_byte) begin
         $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
         failures++;
      end
      if (got.close_code !== want.close_code) begin
         $error("close_code: expected %0h, got %0h", want.close_code, got.close_code);
         failures++;
      end
      if (got.error_code !== want.error_code) begin
         $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
         failures++;
      end
      if (got.empty_res !== want.empty_res) begin
         $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
         failures++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         failures++;
      end
   endfunction
endclass

module tb_websocket_frame_deframer_core;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_channel;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_close_code;
   logic [1:0]  rsp_error_code;
   logic        rsp_empty_res;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = 32'd0;

   deframe_scoreboard sb;

   int          tx_bytes = 0;
   logic        tx_burst = 1'b0;
   logic        tx_force = 1'b0;
   logic        rx_burst = 1'b0;
   int          hold_rsp_cycles = 0;
   logic [31:0] cur_limit = MAX_FRAME_LENGTH_RESET;

   websocket_frame_deframer_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_channel    (rsp_channel),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_close_code (rsp_close_code),
      .rsp_error_code (rsp_error_code),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("websocket_frame_deframer_core regression: fail");
      $finish;
   end

   // result side: per-result stall, plus a long hold-off on request
   initial begin
      rsp_type rx_sample;
      logic    have;
      int      stall;
      have  = 1'b0;
      stall = 0;
      while (reset) @(negedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            rx_sample.channel    = rsp_channel;
            rx_sample.data_byte  = rsp_data_byte;
            rx_sample.close_code = rsp_close_code;
            rx_sample.error_code = rsp_error_code;
            rx_sample.empty_res  = rsp_empty_res;
            rx_sample.last       = rsp_last;
            have = 1'b1;
         end
         @(negedge clock);
         if (have) begin
            sb.check_rsp(rx_sample);
            have  = 1'b0;
            stall = rx_burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
         end
         if (hold_rsp_cycles > 0) begin
            stall           = hold_rsp_cycles;
            hold_rsp_cycles = 0;
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (tx_burst || tx_force) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (!req_ready);
      sb.take_byte(b);
      tx_bytes++;
   endtask

   // sender goes quiet until every pending result is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic apply_settings(input logic demask, input logic [31:0] limit);
      write_csr(CSR_DEMASK_ENABLE, {31'd0, demask});
      write_csr(CSR_MAX_FRAME_LENGTH, limit);
      cur_limit = limit;
   endtask

   function automatic int pick_form(input logic [63:0] len);
      int r;
      r = $urandom_range(0, 5);
      if (len > 64'd125) return (r < 3) ? 1 : 2;
      return (r == 0) ? 1 : (r == 1) ? 2 : 0;
   endfunction

   // form 0: 7-bit length, 1: 16-bit extended, 2: 64-bit extended
   task automatic send_header(input logic [3:0] op, input logic masked,
                              input logic [63:0] len, input int form);
      logic [3:0]  flags;
      logic [31:0] key;
      flags = 4'($urandom_range(0, 15));
      key   = $urandom;
      send_byte({flags, op});
      if (form == 0) begin
         send_byte({masked, len[6:0]});
      end else if (form == 1) begin
         send_byte({masked, LEN7_EXT16});
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end else begin
         send_byte({masked, LEN7_EXT64});
         for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
      end
   endtask

   task automatic send_frame(input logic [3:0] op, input logic masked,
                             input logic [63:0] len, input int form);
      send_header(op, masked, len, form);
      for (int i = 0; i < int'(len); i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic random_frame();
      int          r;
      logic [3:0]  op;
      logic [63:0] len;
      r = $urandom_range(0, 9);
      op = (r < 3) ? OP_TEXT : (r < 5) ? OP_BINARY : (r < 7) ? OP_CONT :
           (r < 9) ? OP_PING : OP_PONG;
      r = $urandom_range(0, 19);
      if (r < 2) begin
         len = 64'd0;
      end else if (r == 19) begin
         len = 64'($urandom_range(13, 125));
      end else begin
         len = 64'($urandom_range(1, 12));
      end
      if (len > {32'd0, cur_limit}) len = {32'd0, cur_limit};
      send_frame(op, $urandom_range(0, 3) != 0, len, pick_form(len));
      if ($urandom_range(0, 14) == 0) drain();
   endtask

   initial begin
      int          kind;
      int          phase_start;
      int          ev;
      int          v;
      logic        pressure_done;
      logic [3:0]  op;
      logic [31:0] limit;
      logic [63:0] len;

      sb = new();
      kind          = 0;
      pressure_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames at reset settings
      send_frame(OP_TEXT, 1'b0, 64'd3, 0);
      send_frame(OP_TEXT, 1'b1, 64'd4, 0);
      send_frame(OP_BINARY, 1'b1, 64'd2, 0);
      send_frame(OP_CONT, 1'b0, 64'd3, 0);
      send_frame(OP_TEXT, 1'b0, 64'd0, 0);
      send_frame(OP_CONT, 1'b1, 64'd0, 0);
      send_frame(OP_BINARY, 1'b0, 64'd5, 1);
      send_frame(OP_TEXT, 1'b1, 64'd2, 2);
      send_frame(OP_PING, 1'b1, 64'd3, 0);
      send_frame(OP_PING, 1'b0, 64'd0, 0);
      send_frame(OP_PONG, 1'b1, 64'd2, 0);
      send_frame(OP_PONG, 1'b0, 64'd0, 0);

      while (tx_bytes < 340) begin
         drain();
         case (kind % 6)
            0: apply_settings(1'b0, 32'hffff_ffff);
            1: apply_settings(1'b1, 32'd0);
            2: apply_settings(1'b0, 32'd1);
            3: apply_settings(1'b1, 32'd125);
            4: apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 300));
            default: apply_settings(1'b1, MAX_FRAME_LENGTH_RESET);
         endcase
         if (!pressure_done && kind % 6 == 3) begin
            // result side blocked while ping bytes keep coming: the queue fills up
            hold_rsp_cycles = 250;
            tx_force        = 1'b1;
            send_frame(OP_PING, 1'b1, 64'd40, 0);
            tx_force        = 1'b0;
            pressure_done   = 1'b1;
            drain();
         end
         phase_start = tx_bytes;
         while (tx_bytes - phase_start < 45 && tx_bytes < 360) random_frame();
         kind++;
      end

      // one stream-ending event, then bytes that must be dropped
      drain();
      ev = $urandom_range(0, 6);
      case (ev)
         0: begin
            v  = $urandom_range(0, 9);
            op = (v < 5) ? 4'(v + 3) : 4'(v + 6);
            send_byte({4'($urandom_range(0, 15)), op});
         end
         1: begin
            apply_settings(1'($urandom_range(0, 1)), 32'hffff_ffff);
            send_header(OP_CLOSE, 1'($urandom_range(0, 1)), 64'd1, pick_form(64'd1));
         end
         2: begin
            apply_settings(1'b1, 32'hffff_ffff);
            len = 64'($urandom_range(126, 300));
            send_header(OP_PING, 1'($urandom_range(0, 1)), len, pick_form(len));
         end
         3: begin
            v = $urandom_range(0, 2);
            if (v == 0) begin
               apply_settings(1'b1, 32'hffff_ffff);
               len = {32'($urandom_range(1, 32'hffff)), 32'($urandom)};
               send_header(OP_BINARY, 1'($urandom_range(0, 1)), len, 2);
            end else if (v == 1) begin
               limit = $urandom_range(0, 200);
               apply_settings(1'b0, limit);
               len = {32'd0, limit} + 64'd1;
               op  = ($urandom_range(0, 1) == 0) ? OP_TEXT : OP_PONG;
               send_header(op, 1'($urandom_range(0, 1)), len, pick_form(len));
            end else begin
               // limit is checked before the one-byte close rule
               apply_settings(1'b1, 32'd0);
               send_header(OP_CLOSE, 1'($urandom_range(0, 1)), 64'd1, pick_form(64'd1));
            end
         end
         4: send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 64'd0, pick_form(64'd0));
         5: send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 64'd2, pick_form(64'd2));
         default: begin
            len = 64'($urandom_range(3, 12));
            send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), len, pick_form(len));
         end
      endcase
      repeat (20) send_byte(8'($urandom_range(0, 255)));

      drain();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.expected_rsp.size() == 0) begin
         $display("websocket_frame_deframer_core regression: pass");
      end else begin
         $display("websocket_frame_deframer_core regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/wsd_pkg.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_rsp_queue.sv
rtl/core/websocket_frame_deframer_core.sv
tb/tb_websocket_frame_deframer_core.sv
